/* design/ampd_pkg.sv */
// shared constants and types for the accelerometer motion and posture detector
// no dependencies
package ampd_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int GAIN_BITS         = 16;
    localparam int ONE_G             = 16384;
    localparam int TIME_BITS         = 32;

    // configuration register indexes
    localparam logic [2:0] REG_FILTER_GAIN = 3'd0;
    localparam logic [2:0] REG_MAG_THRESH  = 3'd1;
    localparam logic [2:0] REG_TILT_THRESH = 3'd2;
    localparam logic [2:0] REG_HOLD_TIME   = 3'd3;
    localparam logic [2:0] REG_RECAL_TIME  = 3'd4;

    // operand select for the shared square-multiply unit
    typedef enum logic [2:0] {
        OP_AX, OP_AY, OP_AZ, OP_DX, OP_DY, OP_DZ
    } sq_sel_t;

    // operand select for the filter gain step
    typedef enum logic [1:0] {
        FS_MEAN, FS_GX, FS_GY, FS_GZ
    } flt_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load;       // capture input transaction
        logic     seed;       // seed filters from sample
        logic     sq_clr;     // clear sum of squares
        logic     sq_acc;     // accumulate one square
        sq_sel_t  sq_sel;
        logic     rt_start;   // start square root on sum
        logic     rt_step;    // one square root iteration
        logic     mag_take;   // keep root as magnitude
        logic     dev_calc;   // deviation and tilt differences
        logic     flt_mul;    // multiply stage of filter update
        logic     flt_upd;    // accumulate stage of filter update
        flt_sel_t flt_sel;
        logic     decide;     // final flags and result register
    } ampd_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic rt_done;
        logic primed;
    } ampd_sts_t;

endpackage

/* design/ampd_ctrl.sv */
// controller state machine for the motion and posture detector
// depends on ampd_pkg
module ampd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_fire,
    input  logic               out_free,
    input  ampd_pkg::ampd_sts_t sts,
    output ampd_pkg::ampd_cmd_t cmd,
    output logic               busy
);
    import ampd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_DIFF, S_TSQ, S_TROOT, S_FMUL, S_FUPD, S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [1:0]  cnt_reg, cnt_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.sq_sel = OP_AX;
        cmd.flt_sel = FS_MEAN;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    cmd.sq_clr = 1'b1;
                    cnt_next   = 2'd0;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.sq_acc = 1'b1;
                cmd.sq_sel = sq_sel_t'({1'b0, cnt_reg});
                if (cnt_reg == 2'd2)
                begin
                    state_next = S_ROOT;
                    cnt_next   = 2'd0;
                end
                else
                    cnt_next = cnt_reg + 2'd1;
            end
            S_ROOT:
            begin
                if (cnt_reg == 2'd0)
                begin
                    cmd.rt_start = 1'b1;
                    cnt_next     = 2'd1;
                end
                else if (sts.rt_done)
                begin
                    cmd.mag_take = 1'b1;
                    cmd.seed     = !sts.primed;
                    state_next   = S_DIFF;
                end
                else
                    cmd.rt_step = 1'b1;
            end
            S_DIFF:
            begin
                cmd.dev_calc = 1'b1;
                cmd.sq_clr   = 1'b1;
                cnt_next     = 2'd0;
                state_next   = S_TSQ;
            end
            S_TSQ:
            begin
                cmd.sq_acc = 1'b1;
                cmd.sq_sel = sq_sel_t'(3'd3 + {1'b0, cnt_reg});
                if (cnt_reg == 2'd2)
                begin
                    state_next = S_TROOT;
                    cnt_next   = 2'd0;
                end
                else
                    cnt_next = cnt_reg + 2'd1;
            end
            S_TROOT:
            begin
                if (cnt_reg == 2'd0)
                begin
                    cmd.rt_start = 1'b1;
                    cnt_next     = 2'd1;
                end
                else if (sts.rt_done)
                begin
                    cnt_next   = 2'd0;
                    state_next = S_FMUL;
                end
                else
                    cmd.rt_step = 1'b1;
            end
            S_FMUL:
            begin
                cmd.flt_mul = 1'b1;
                cmd.flt_sel = flt_sel_t'(cnt_reg);
                state_next  = S_FUPD;
            end
            S_FUPD:
            begin
                cmd.flt_upd = 1'b1;
                cmd.flt_sel = flt_sel_t'(cnt_reg);
                cnt_next    = cnt_reg + 2'd1;
                state_next  = (cnt_reg == 2'd3) ? S_DONE : S_FMUL;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.decide = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* design/ampd_dp.sv */
// datapath: square accumulator, bit-serial square root, filters, timers
// depends on ampd_pkg
module ampd_dp #(
    parameter int SAMPLE_BITS   = ampd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = ampd_pkg::FRACTION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ampd_pkg::ampd_cmd_t      cmd,
    output ampd_pkg::ampd_sts_t      sts,
    input  logic [SAMPLE_BITS-1:0]   in_x,
    input  logic [SAMPLE_BITS-1:0]   in_y,
    input  logic [SAMPLE_BITS-1:0]   in_z,
    input  logic [31:0]              in_time,
    input  logic [15:0]              filter_gain,
    input  logic [15:0]              mag_thresh,
    input  logic [16:0]              tilt_thresh,
    input  logic [19:0]              hold_time,
    input  logic [19:0]              recal_time,
    output logic [79:0]              result
);
    import ampd_pkg::*;

    localparam int SQ_W  = 2 * SAMPLE_BITS + 1;        // one square of a difference
    localparam int SUM_W = SQ_W + 2;                   // sum of three
    localparam int RT_W  = (SUM_W + 1) / 2;            // root width
    localparam int RT_N  = (SUM_W + 1) / 2;            // iterations
    localparam int RC_W  = $clog2(RT_N + 1);
    localparam int D_W   = SAMPLE_BITS + 1;            // difference width
    localparam int ST_W  = SAMPLE_BITS + FRACTION_BITS + 2; // filter state, signed
    localparam int DF_W  = ST_W + 1;
    localparam int PR_W  = DF_W + GAIN_BITS + 1;

    // captured sample
    logic signed [SAMPLE_BITS-1:0] ax_reg, ay_reg, az_reg;
    logic [31:0]                   now_reg;

    // filter state
    logic signed [ST_W-1:0] mean_reg, gx_reg, gy_reg, gz_reg;
    logic                   primed_reg;
    logic [31:0]            last_act_reg, recal_end_reg, quiet_st_reg;

    // work registers
    logic signed [D_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [RT_W-1:0]        mag_reg, dev_reg;
    logic [SUM_W-1:0]       rem_reg;
    logic [SUM_W-1:0]       res_reg;
    logic [RC_W-1:0]        rcnt_reg;
    logic signed [PR_W-1:0] prod_reg;
    logic [79:0]            result_reg;

    // square operand select
    logic signed [D_W-1:0] sq_op;
    always_comb
    begin
        case (cmd.sq_sel)
            OP_AX:   sq_op = D_W'(ax_reg);
            OP_AY:   sq_op = D_W'(ay_reg);
            OP_AZ:   sq_op = D_W'(az_reg);
            OP_DX:   sq_op = dx_reg;
            OP_DY:   sq_op = dy_reg;
            OP_DZ:   sq_op = dz_reg;
            default: sq_op = '0;
        endcase
    end
    logic signed [2*D_W-1:0] sq_full;
    assign sq_full = sq_op * sq_op;

    // square root iteration, one result bit per pair of input bits
    logic [SUM_W-1:0] rt_bit, rt_trial;
    assign rt_bit   = SUM_W'(1) << (2 * (RT_N - 32'(rcnt_reg)));
    assign rt_trial = res_reg + rt_bit;

    // filter select
    logic signed [ST_W-1:0] f_state;
    logic signed [ST_W-1:0] f_target;
    always_comb
    begin
        case (cmd.flt_sel)
            FS_MEAN: begin f_state = mean_reg; f_target = ST_W'({1'b0, mag_reg}); end
            FS_GX:   begin f_state = gx_reg;   f_target = ST_W'(ax_reg); end
            FS_GY:   begin f_state = gy_reg;   f_target = ST_W'(ay_reg); end
            FS_GZ:   begin f_state = gz_reg;   f_target = ST_W'(az_reg); end
            default: begin f_state = mean_reg; f_target = '0; end
        endcase
    end
    logic signed [DF_W-1:0] f_diff;
    assign f_diff = DF_W'(f_target <<< FRACTION_BITS) - DF_W'(f_state);
    logic signed [PR_W-1:0] f_prod;
    assign f_prod = PR_W'(f_diff) * PR_W'($signed({1'b0, filter_gain}));
    logic signed [ST_W-1:0] f_new;
    assign f_new = f_state + ST_W'(prod_reg >>> GAIN_BITS);

    // integer part of the mean and signed deviation of the magnitude
    logic signed [ST_W-1:0]  mean_int;
    logic signed [RT_W+1:0]  dev_s;
    assign mean_int = mean_reg >>> FRACTION_BITS;
    assign dev_s    = $signed({2'b00, mag_reg}) - (RT_W+2)'(mean_int);

    // decision logic
    logic        posture, active, moving, recal;
    logic [31:0] now_last, recal_end_new, recal_diff;
    assign posture       = {1'b0, res_reg} > (SUM_W+1)'(tilt_thresh);
    assign active        = ((RT_W+1)'(dev_reg) > (RT_W+1)'(mag_thresh)) || posture;
    assign now_last      = now_reg - last_act_reg;
    assign moving        = active || (now_last < {12'd0, hold_time});
    assign recal_end_new = now_reg + {12'd0, hold_time} + {12'd0, recal_time};
    assign recal_diff    = (active && posture ? recal_end_new : recal_end_reg) - now_reg;
    assign recal         = (recal_diff != 32'd0) && !recal_diff[31];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            mean_reg      <= ST_W'(ONE_G) <<< FRACTION_BITS;
            gx_reg        <= '0;
            gy_reg        <= '0;
            gz_reg        <= ST_W'(ONE_G) <<< FRACTION_BITS;
            last_act_reg  <= '0;
            recal_end_reg <= '0;
            quiet_st_reg  <= '0;
        end
        else
        begin
            if (cmd.seed)
            begin
                primed_reg   <= 1'b1;
                mean_reg     <= ST_W'({1'b0, res_reg[RT_W-1:0]}) <<< FRACTION_BITS;
                gx_reg       <= ST_W'(ax_reg) <<< FRACTION_BITS;
                gy_reg       <= ST_W'(ay_reg) <<< FRACTION_BITS;
                gz_reg       <= ST_W'(az_reg) <<< FRACTION_BITS;
                quiet_st_reg <= now_reg;
            end
            if (cmd.flt_upd)
            begin
                case (cmd.flt_sel)
                    FS_MEAN: mean_reg <= f_new;
                    FS_GX:   gx_reg   <= f_new;
                    FS_GY:   gy_reg   <= f_new;
                    FS_GZ:   gz_reg   <= f_new;
                    default: mean_reg <= f_new;
                endcase
            end
            if (cmd.decide && active)
            begin
                last_act_reg <= now_reg;
                quiet_st_reg <= now_reg;
                if (posture)
                    recal_end_reg <= recal_end_new;
            end
        end
    end

    // payload and work registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg  <= in_x;
            ay_reg  <= in_y;
            az_reg  <= in_z;
            now_reg <= in_time;
        end
        if (cmd.sq_clr)
            sum_reg <= '0;
        else if (cmd.sq_acc)
            sum_reg <= sum_reg + SUM_W'(sq_full);
        if (cmd.rt_start)
        begin
            rem_reg  <= sum_reg;
            res_reg  <= '0;
            rcnt_reg <= RC_W'(1);
        end
        else if (cmd.rt_step)
        begin
            if (rem_reg >= rt_trial)
            begin
                rem_reg <= rem_reg - rt_trial;
                res_reg <= (res_reg >> 1) + rt_bit;
            end
            else
                res_reg <= res_reg >> 1;
            rcnt_reg <= rcnt_reg + RC_W'(1);
        end
        if (cmd.mag_take)
            mag_reg <= res_reg[RT_W-1:0];
        if (cmd.dev_calc)
        begin
            dev_reg <= dev_s[RT_W+1] ? RT_W'(-dev_s) : RT_W'(dev_s);
            dx_reg  <= D_W'(ax_reg) - D_W'(gx_reg >>> FRACTION_BITS);
            dy_reg  <= D_W'(ay_reg) - D_W'(gy_reg >>> FRACTION_BITS);
            dz_reg  <= D_W'(az_reg) - D_W'(gz_reg >>> FRACTION_BITS);
        end
        if (cmd.flt_mul)
            prod_reg <= f_prod;
        if (cmd.decide)
        begin
            result_reg[0]     <= moving;
            result_reg[1]     <= recal;
            result_reg[2]     <= posture;
            result_reg[18:3]  <= 16'(mag_reg);
            result_reg[34:19] <= 16'(dev_reg);
            result_reg[66:35] <= moving ? 32'd0 : now_reg - quiet_st_reg;
            result_reg[67]    <= moving || recal;
            result_reg[79:68] <= '0;
        end
    end

    assign sts.rt_done = (rcnt_reg == RC_W'(RT_N + 1));
    assign sts.primed  = primed_reg;
    assign result      = result_reg;

endmodule

/* design/accel_motion_posture_detector.sv */
// Accelerometer motion and posture detector, one result per sample.
// From input transaction to result register: three square accumulations, a
// bit-serial square root, a difference step, three more square accumulations,
// a second root and four filter updates; each root: SAMPLE_BITS+2 steps, start, finish.
// One sample at a time; the next is accepted once the result register is written.
// rst_n clears filters to their defaults, timers to zero, config registers to defaults.
module accel_motion_posture_detector #(
    parameter int SAMPLE_BITS   = ampd_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = ampd_pkg::FRACTION_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // accel_x, accel_y, accel_z, time_now
    input  logic [((3*SAMPLE_BITS+32+7)/8)*8-1:0] s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // moving, recalibrating, posture_flag, magnitude, deviation, quiet_time, fast_adapt
    output logic [71:0]                m_axis_tdata,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [2:0]                 cfg_index,
    input  logic [19:0]                cfg_data
);
    import ampd_pkg::*;

    ampd_cmd_t   cmd;
    ampd_sts_t   sts;
    logic        busy;
    logic        out_valid_reg;
    logic [79:0] result;
    logic [15:0] gain_reg, mthr_reg;
    logic [16:0] tthr_reg;
    logic [19:0] hold_reg, recal_reg;

    assign s_axis_tready = !busy;
    assign cfg_ready     = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= 16'd3277;
            mthr_reg  <= 16'd819;
            tthr_reg  <= 17'd3277;
            hold_reg  <= 20'd2000;
            recal_reg <= 20'd30000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FILTER_GAIN: gain_reg  <= cfg_data[15:0];
                REG_MAG_THRESH:  mthr_reg  <= cfg_data[15:0];
                REG_TILT_THRESH: tthr_reg  <= cfg_data[16:0];
                REG_HOLD_TIME:   hold_reg  <= cfg_data;
                REG_RECAL_TIME:  recal_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.decide)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    ampd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid),
        .out_free (!out_valid_reg || m_axis_tready),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy)
    );

    ampd_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .in_x        (s_axis_tdata[SAMPLE_BITS-1:0]),
        .in_y        (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .in_z        (s_axis_tdata[3*SAMPLE_BITS-1:2*SAMPLE_BITS]),
        .in_time     (s_axis_tdata[3*SAMPLE_BITS+31:3*SAMPLE_BITS]),
        .filter_gain (gain_reg),
        .mag_thresh  (mthr_reg),
        .tilt_thresh (tthr_reg),
        .hold_time   (hold_reg),
        .recal_time  (recal_reg),
        .result      (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = result[71:0];

endmodule
